// File: rtl/btc_pkg.sv
// Package for the beat tracker clock: word types, operation codes and widths.
// No dependencies; imported by beat_tracker_clock_unit.
`default_nettype none

package btc_pkg;

  // Field widths
  localparam int unsigned TIME_W    = 48;  // timestamps, signed
  localparam int unsigned FRAC_BITS = 16;  // fraction bits of internal times
  localparam int unsigned COUNT_W   = 32;  // beat counters
  localparam int unsigned PERIOD_W  = 32;  // beat period, Q16.16 ms
  localparam int unsigned BPM_W     = 16;  // tempo, Q10.6
  localparam int unsigned BPM_FRAC  = 6;

  // Subdivision mode divides the period by 2**SUBDIV_SHIFT
  localparam int unsigned SUBDIV_SHIFT = 3;

  // Datapath widths
  localparam int unsigned DIFF_W    = TIME_W + 1;            // exact stamp difference
  localparam int unsigned DVD_W     = DIFF_W + FRAC_BITS;    // dividend shift register
  localparam int unsigned V_W       = DVD_W + 1;             // final signed combine
  localparam int unsigned PROD_W    = 2 * PERIOD_W;          // period times count
  localparam int unsigned DIV_STEPS = DVD_W;                 // one quotient bit per step
  localparam int unsigned MUL_STEPS = COUNT_W;               // one multiplier bit per step
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS + 1);

  // 60000 ms per minute, tempo carries BPM_FRAC fraction bits
  localparam logic [DVD_W-1:0] PERIOD_NUM =
    DVD_W'(64'd60000 << (BPM_FRAC + FRAC_BITS));

  typedef enum logic [1:0] {
    OP_RESTART = 2'd0,
    OP_TEMPO   = 2'd1,
    OP_POLL    = 2'd2,
    OP_QUERY   = 2'd3
  } op_e;

  typedef struct packed {
    op_e                      op;
    logic signed [TIME_W-1:0] now_ms;
    logic [BPM_W-1:0]         tempo_bpm;
  } in_word_t;

  typedef struct packed {
    logic                      beat_event;
    logic signed [COUNT_W-1:0] beat_count;
    logic [TIME_W-1:0]         since_ms;
    logic signed [TIME_W-1:0]  remaining_ms;
    logic [COUNT_W-1:0]        resync_count;
  } out_word_t;

endpackage

`default_nettype wire

// File: rtl/beat_tracker_clock_unit.sv
// Beat tracker clock: tempo-driven beat counter with bit-serial divider and multiplier.
// Depends on btc_pkg (word types, operation codes, widths).
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   in      | in_valid_i, in_ready_o, in_word_i        | word in
//   out     | out_valid_o, out_ready_i, out_word_o     | word out
//   cfg     | cfg_valid_i, cfg_ready_o, cfg_data_i     | count_mode write
//
// Every word passes, from accept to the next possible accept, through one load,
// 65 steps of the restoring divider (one quotient bit per cycle, the shift-add
// multiplier runs in the first 32 of them) and one finish step.
// The finish cycle waits only while the output register still holds an untaken word.
// Reset clears all state; count_mode comes up as 1 (whole beats).
// The cfg port is always ready.
`default_nettype none

module beat_tracker_clock_unit
  import btc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_word_t  in_word_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_word_t      out_word_o,
  input  wire logic      cfg_valid_i,
  output logic           cfg_ready_o,
  input  wire logic      cfg_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_e;

  // Saturate a 33-bit signed sum to 32 bits
  function automatic logic [COUNT_W-1:0] sat_count(input logic [COUNT_W:0] s);
    logic [COUNT_W-1:0] r;
    r = s[COUNT_W-1:0];
    if (s[COUNT_W] != s[COUNT_W-1]) begin
      r = s[COUNT_W] ? {1'b1, {(COUNT_W-1){1'b0}}} : {1'b0, {(COUNT_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Architectural state
  state_e              state_q, state_d;
  logic                count_mode_q, count_mode_d;
  logic [PERIOD_W-1:0] beat_period_q, beat_period_d;
  logic [COUNT_W-1:0]  count_value_q, count_value_d;
  logic [COUNT_W-1:0]  drift_count_q, drift_count_d;
  logic [TIME_W-1:0]   drift_stamp_q, drift_stamp_d;
  logic [TIME_W-1:0]   last_stamp_q, last_stamp_d;
  logic [COUNT_W-1:0]  resyncs_q, resyncs_d;

  // Per-word working registers
  op_e                 op_q, op_d;
  logic [TIME_W-1:0]   now_q, now_d;
  logic [DIFF_W-1:0]   x_q, x_d;
  logic                dneg_q, dneg_d;
  logic                resync_q, resync_d;
  logic                tv_neg_q, tv_neg_d;
  logic [DVD_W-1:0]    dvd_q, dvd_d;
  logic [PERIOD_W-1:0] dvs_q, dvs_d;
  logic [PERIOD_W-1:0] rem_q, rem_d;
  logic [PERIOD_W-1:0] quo_q, quo_d;
  logic                ovf_q, ovf_d;
  logic [PROD_W-1:0]   acc_q, acc_d;
  logic [COUNT_W-1:0]  mpl_q, mpl_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  out_word_t           out_q, out_d;

  // Combinational helpers
  logic                accept;
  logic [PERIOD_W-1:0] per;
  logic [DIFF_W-1:0]   diff_a, diff_b, now_x;
  logic [COUNT_W:0]    tv;
  logic [COUNT_W-1:0]  tv_mag;
  logic [PERIOD_W:0]   rem_sh, rem_sub;
  logic                rem_ge;
  logic [PERIOD_W:0]   mul_sum;
  logic [PERIOD_W-1:0] per_q, per_m, per_new;
  logic                big_pos, big_neg;
  logic [COUNT_W:0]    sq, cnt_sum, drift_sum;
  logic [COUNT_W-1:0]  cnt_new;
  logic                beat;
  logic [V_W-1:0]      vx, vp_pos, vp, v;
  logic [TIME_W-1:0]   since_sat, remain_sat;
  logic                remain_fits;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign accept      = in_valid_i && in_ready_o;

  // Operands at accept
  always_comb begin
    per    = (beat_period_q == '0) ? PERIOD_W'(1) : beat_period_q;
    now_x  = {in_word_i.now_ms[TIME_W-1], in_word_i.now_ms};
    diff_a = now_x - {drift_stamp_q[TIME_W-1], drift_stamp_q};
    diff_b = {drift_stamp_q[TIME_W-1], drift_stamp_q} - now_x;
    tv     = {count_value_q[COUNT_W-1], count_value_q} + (COUNT_W+1)'(1);
    tv_mag = tv[COUNT_W] ? COUNT_W'(-tv) : tv[COUNT_W-1:0];
  end

  // One divider step and one multiplier step
  always_comb begin
    rem_sh  = {rem_q, dvd_q[DVD_W-1]};
    rem_ge  = (rem_sh >= {1'b0, dvs_q});
    rem_sub = rem_sh - {1'b0, dvs_q};
    mul_sum = {1'b0, acc_q[PROD_W-1:PERIOD_W]} + (mpl_q[0] ? {1'b0, per} : '0);
  end

  // Finish: period, count, signed combine and saturation
  always_comb begin
    per_q   = ovf_q ? '1 : quo_q;
    per_m   = count_mode_q ? per_q : (per_q >> SUBDIV_SHIFT);
    per_new = (per_m == '0) ? PERIOD_W'(1) : per_m;

    big_pos = ovf_q | quo_q[PERIOD_W-1];
    big_neg = ovf_q | (quo_q[PERIOD_W-1] & (|quo_q[PERIOD_W-2:0]));
    if (dneg_q) begin
      sq = big_neg ? {2'b11, {(COUNT_W-1){1'b0}}} : -{1'b0, quo_q};
    end else begin
      sq = big_pos ? {2'b00, {(COUNT_W-1){1'b1}}} : {1'b0, quo_q};
    end
    cnt_sum   = sq + {drift_count_q[COUNT_W-1], drift_count_q};
    cnt_new   = sat_count(cnt_sum);
    beat      = $signed(cnt_new) > $signed(count_value_q);
    drift_sum = {drift_count_q[COUNT_W-1], drift_count_q}
              + {count_value_q[COUNT_W-1], count_value_q};

    vx     = {x_q[DIFF_W-1], x_q, {FRAC_BITS{1'b0}}};
    vp_pos = {{(V_W-PROD_W){1'b0}}, acc_q};
    vp     = tv_neg_q ? (~vp_pos + V_W'(1)) : vp_pos;
    v      = vx - vp;

    if (v[V_W-1]) begin
      since_sat = '0;
    end else if (|v[V_W-2:TIME_W]) begin
      since_sat = '1;
    end else begin
      since_sat = v[TIME_W-1:0];
    end

    remain_fits = (&v[V_W-1:TIME_W-1]) | ~(|v[V_W-1:TIME_W-1]);
    if (remain_fits) begin
      remain_sat = v[TIME_W-1:0];
    end else begin
      remain_sat = v[V_W-1] ? {1'b1, {(TIME_W-1){1'b0}}} : {1'b0, {(TIME_W-1){1'b1}}};
    end
  end

  // Next state
  always_comb begin
    state_d       = state_q;
    count_mode_d  = count_mode_q;
    beat_period_d = beat_period_q;
    count_value_d = count_value_q;
    drift_count_d = drift_count_q;
    drift_stamp_d = drift_stamp_q;
    last_stamp_d  = last_stamp_q;
    resyncs_d     = resyncs_q;
    op_d          = op_q;
    now_d         = now_q;
    x_d           = x_q;
    dneg_d        = dneg_q;
    resync_d      = resync_q;
    tv_neg_d      = tv_neg_q;
    dvd_d         = dvd_q;
    dvs_d         = dvs_q;
    rem_d         = rem_q;
    quo_d         = quo_q;
    ovf_d         = ovf_q;
    acc_d         = acc_q;
    mpl_d         = mpl_q;
    cnt_d         = cnt_q;
    out_valid_d   = out_valid_q;
    out_d         = out_q;

    // cfg write: by contract taken only while idle; the block itself does not enforce it
    if (cfg_valid_i) begin
      count_mode_d = cfg_data_i;
    end

    // output word taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d  = ST_RUN;
          op_d     = in_word_i.op;
          now_d    = in_word_i.now_ms;
          // query flips both terms: the finish subtract then gives (count+1)*period - now
          x_d      = (in_word_i.op == OP_QUERY) ? -now_x : diff_a;
          dneg_d   = diff_a[DIFF_W-1];
          resync_d = $signed(last_stamp_q) > $signed(in_word_i.now_ms);
          tv_neg_d = tv[COUNT_W] ^ (in_word_i.op == OP_QUERY);
          rem_d    = '0;
          quo_d    = '0;
          ovf_d    = 1'b0;
          acc_d    = '0;
          mpl_d    = tv_mag;
          cnt_d    = '0;
          if (in_word_i.op inside {OP_RESTART, OP_TEMPO}) begin
            dvd_d = PERIOD_NUM;
            dvs_d = {{(PERIOD_W-BPM_W){1'b0}}, in_word_i.tempo_bpm};
          end else begin
            dvd_d = {(diff_a[DIFF_W-1] ? diff_b : diff_a), {FRAC_BITS{1'b0}}};
            dvs_d = per;
          end
        end
      end

      ST_RUN: begin
        // restoring divider, one quotient bit a cycle
        dvd_d = {dvd_q[DVD_W-2:0], 1'b0};
        rem_d = rem_ge ? rem_sub[PERIOD_W-1:0] : rem_sh[PERIOD_W-1:0];
        quo_d = {quo_q[PERIOD_W-2:0], rem_ge};
        ovf_d = ovf_q | quo_q[PERIOD_W-1];
        // shift-add multiplier, period times |count+1|
        if (cnt_q < CNT_W'(MUL_STEPS)) begin
          acc_d = {mul_sum, acc_q[PERIOD_W-1:1]};
          mpl_d = mpl_q >> 1;
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_FIN;
        end
      end

      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          state_d                  = ST_IDLE;
          out_valid_d              = 1'b1;
          out_d.beat_event         = 1'b0;
          out_d.since_ms           = '0;
          out_d.remaining_ms       = '0;
          out_d.beat_count         = count_value_q;
          out_d.resync_count       = resyncs_q;
          case (op_q)
            OP_RESTART: begin
              beat_period_d      = per_new;
              count_value_d      = '0;
              drift_count_d      = '0;
              drift_stamp_d      = '0;
              resyncs_d          = '0;
              last_stamp_d       = now_q;
              out_d.beat_count   = '0;
              out_d.resync_count = '0;
            end
            OP_TEMPO: begin
              beat_period_d = per_new;
              drift_stamp_d = now_q;
              drift_count_d = sat_count(drift_sum);
            end
            OP_POLL: begin
              last_stamp_d = now_q;
              if (resync_q) begin
                resyncs_d          = resyncs_q + COUNT_W'(1);
                drift_stamp_d      = drift_stamp_q - last_stamp_q + now_q;
                out_d.resync_count = resyncs_q + COUNT_W'(1);
              end else begin
                count_value_d    = cnt_new;
                out_d.beat_count = cnt_new;
                out_d.beat_event = beat;
                out_d.since_ms   = beat ? since_sat : '0;
              end
            end
            OP_QUERY: begin
              out_d.remaining_ms = remain_sat;
            end
            default: begin
              out_d.remaining_ms = '0;
            end
          endcase
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      count_mode_q  <= 1'b1;
      beat_period_q <= '0;
      count_value_q <= '0;
      drift_count_q <= '0;
      drift_stamp_q <= '0;
      last_stamp_q  <= '0;
      resyncs_q     <= '0;
      op_q          <= OP_RESTART;
      now_q         <= '0;
      x_q           <= '0;
      dneg_q        <= 1'b0;
      resync_q      <= 1'b0;
      tv_neg_q      <= 1'b0;
      dvd_q         <= '0;
      dvs_q         <= '0;
      rem_q         <= '0;
      quo_q         <= '0;
      ovf_q         <= 1'b0;
      acc_q         <= '0;
      mpl_q         <= '0;
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      state_q       <= state_d;
      count_mode_q  <= count_mode_d;
      beat_period_q <= beat_period_d;
      count_value_q <= count_value_d;
      drift_count_q <= drift_count_d;
      drift_stamp_q <= drift_stamp_d;
      last_stamp_q  <= last_stamp_d;
      resyncs_q     <= resyncs_d;
      op_q          <= op_d;
      now_q         <= now_d;
      x_q           <= x_d;
      dneg_q        <= dneg_d;
      resync_q      <= resync_d;
      tv_neg_q      <= tv_neg_d;
      dvd_q         <= dvd_d;
      dvs_q         <= dvs_d;
      rem_q         <= rem_d;
      quo_q         <= quo_d;
      ovf_q         <= ovf_d;
      acc_q         <= acc_d;
      mpl_q         <= mpl_d;
      cnt_q         <= cnt_d;
      out_valid_q   <= out_valid_d;
      out_q         <= out_d;
    end
  end

endmodule

`default_nettype wire
